@@ rtl/pending_request_timeout_table_macros.svh @@
// Assertion macros used by the checker file of the pending request table.
`ifndef PENDING_REQUEST_TIMEOUT_TABLE_MACROS_SVH
`define PENDING_REQUEST_TIMEOUT_TABLE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pending request table assertion failed");

// Antecedent implies consequent in the next cycle.
`define PRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pending request table assertion failed");

`endif

@@ rtl/prt_pkg.sv @@
// Types, codes and constants of the pending request timeout table.
package prt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_REMOVE_ID = 2'd1;
    localparam logic [1:0] OP_REMOVE_HD = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_EXPIRED   = 3'd5;
    localparam logic [2:0] ST_TICKNONE  = 3'd6;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] expiry;
        logic [31:0] addr;
        logic [15:0] port;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic match;
        logic expired;
    } cell_stat_t;

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        begin
            wide = {{OCC_W{1'b0}}, cnt};
            return wide[OCC_W-1:0];
        end
    endfunction

endpackage

@@ rtl/prt_if.sv @@
// Request and result channel interfaces of the pending request timeout table.
interface prt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] request_id;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;

    modport source (output valid, op, request_id, peer_addr, peer_port, input ready);
    modport sink (input valid, op, request_id, peer_addr, peer_port, output ready);
endinterface

interface prt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [31:0] entry_addr;
    logic [15:0] entry_port;
    logic [4:0]  occupancy;
    logic        last;

    modport source (output valid, status, entry_id, entry_addr, entry_port, occupancy, last,
                    input ready);
    modport sink (input valid, status, entry_id, entry_addr, entry_port, occupancy, last,
                  output ready);
endinterface

@@ rtl/prt_cell.sv @@
// One table cell: holds an entry, compares its id and expiry, shifts from its neighbour.
module prt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_pkg::cell_ctl_t  ctl,
    input  prt_pkg::entry_t     load_entry,
    input  prt_pkg::entry_t     next_entry,
    input  logic                next_valid,
    input  logic [15:0]         cmp_id,
    input  logic [31:0]         now,
    output prt_pkg::entry_t     entry,
    output prt_pkg::cell_stat_t stat
);

    logic            valid_reg;
    logic            valid_next;
    prt_pkg::entry_t entry_reg;
    prt_pkg::entry_t entry_next;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
        else if (ctl.load)
        begin
            valid_next = 1'b1;
            entry_next = load_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry        = entry_reg;
    assign stat.valid   = valid_reg;
    assign stat.match   = valid_reg && (entry_reg.id == cmp_id);
    assign stat.expired = valid_reg && (entry_reg.expiry <= now);

endmodule

@@ rtl/pending_request_timeout_table.sv @@
// Top level of the pending request timeout table: control sequencer and row of cells.
//
// Requests arrive on req (op, request_id, peer_addr, peer_port) and results leave on
// rsp (status, entry_id, entry_addr, entry_port, occupancy, last). The timeout in
// seconds is to be written through timeout_we / timeout_wdata only while the block is
// idle; the block itself does not enforce this. Entries sit in a row of cells in
// insertion order; a removal shifts the cells behind the removed one forward by one
// place. Insert, remove by id and remove head register the request, then make the
// parallel id compare across the cells and register the result. A new request can be
// taken in the cycle its result is shown, if that result is taken too; a request is
// thus finished before the next one is taken.
// A tick gives one result for every expired entry at the head, one per cycle while
// results are taken, or a single result when none has expired.
// A request is taken only when the sequencer is idle and the result register is free
// or being emptied; a stalled result holds its values and blocks further requests.
// Reset empties the table, clears the seconds counter and sets the timeout to 3.
module pending_request_timeout_table (
    input  logic            clk,
    input  logic            rst_n,
    prt_req_if.sink         req,
    prt_rsp_if.source       rsp,
    input  logic            timeout_we,
    input  logic [15:0]     timeout_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [1:0]                   op_reg;
    logic [1:0]                   op_next;
    logic [15:0]                  id_reg;
    logic [15:0]                  id_next;
    logic [31:0]                  addr_reg;
    logic [31:0]                  addr_next;
    logic [15:0]                  port_reg;
    logic [15:0]                  port_next;
    logic [prt_pkg::CNT_W-1:0]    count_reg;
    logic [prt_pkg::CNT_W-1:0]    count_next;
    logic [31:0]                  now_reg;
    logic [31:0]                  now_next;
    logic [15:0]                  timeout_reg;
    logic [15:0]                  timeout_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [2:0]                   out_status_reg;
    logic [2:0]                   out_status_next;
    prt_pkg::entry_t              out_entry_reg;
    prt_pkg::entry_t              out_entry_next;
    logic [prt_pkg::OCC_W-1:0]    out_occ_reg;
    logic [prt_pkg::OCC_W-1:0]    out_occ_next;
    logic                         out_last_reg;
    logic                         out_last_next;

    prt_pkg::entry_t              cell_entry [prt_pkg::TABLE_DEPTH];
    prt_pkg::cell_stat_t          cell_stat  [prt_pkg::TABLE_DEPTH];
    prt_pkg::cell_ctl_t           cell_ctl   [prt_pkg::TABLE_DEPTH];
    prt_pkg::entry_t              new_entry;

    logic                         req_take;
    logic                         out_free;
    logic                         found;
    logic [prt_pkg::IDX_W-1:0]    pos_idx;
    prt_pkg::entry_t              match_entry;
    logic                         full;

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_take = req.valid && req.ready;

    assign new_entry.id     = id_reg;
    assign new_entry.expiry = now_reg + {16'd0, timeout_reg};
    assign new_entry.addr   = addr_reg;
    assign new_entry.port   = port_reg;

    assign full = (count_reg == prt_pkg::CNT_W'(prt_pkg::TABLE_DEPTH));

    always_comb
    begin
        found       = 1'b0;
        pos_idx     = '0;
        match_entry = '0;
        for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
        begin
            if (cell_stat[i].match)
            begin
                found       = 1'b1;
                pos_idx     = pos_idx | prt_pkg::IDX_W'(i);
                match_entry = match_entry | cell_entry[i];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        addr_next       = addr_reg;
        port_next       = port_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        timeout_next    = timeout_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;
        for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
        begin
            cell_ctl[i] = '0;
        end

        if (timeout_we)
        begin
            timeout_next = timeout_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    op_next   = req.op;
                    id_next   = req.request_id;
                    addr_next = req.peer_addr;
                    port_next = req.peer_port;
                    if (req.op == prt_pkg::OP_TICK)
                    begin
                        now_next   = now_reg + 32'd1;
                        state_next = S_TICK;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b1;
                out_entry_next = '0;
                out_occ_next   = prt_pkg::occ_of(count_reg);
                state_next     = S_IDLE;
                unique case (op_reg)
                    prt_pkg::OP_INSERT:
                    begin
                        if (found)
                        begin
                            out_status_next = prt_pkg::ST_DUPLICATE;
                        end
                        else if (full)
                        begin
                            out_status_next = prt_pkg::ST_FULL;
                        end
                        else
                        begin
                            out_status_next = prt_pkg::ST_INSERTED;
                            count_next      = count_reg + prt_pkg::CNT_W'(1);
                            out_occ_next    = prt_pkg::occ_of(count_next);
                            for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
                            begin
                                cell_ctl[i].load =
                                    (count_reg[prt_pkg::IDX_W-1:0] == prt_pkg::IDX_W'(i));
                            end
                        end
                    end
                    prt_pkg::OP_REMOVE_ID:
                    begin
                        if (found)
                        begin
                            out_status_next = prt_pkg::ST_REMOVED;
                            out_entry_next  = match_entry;
                            count_next      = count_reg - prt_pkg::CNT_W'(1);
                            out_occ_next    = prt_pkg::occ_of(count_next);
                            for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
                            begin
                                cell_ctl[i].shift = (prt_pkg::IDX_W'(i) >= pos_idx);
                            end
                        end
                        else
                        begin
                            out_status_next = prt_pkg::ST_NOTFOUND;
                        end
                    end
                    prt_pkg::OP_REMOVE_HD:
                    begin
                        if (cell_stat[0].valid)
                        begin
                            out_status_next = prt_pkg::ST_REMOVED;
                            out_entry_next  = cell_entry[0];
                            count_next      = count_reg - prt_pkg::CNT_W'(1);
                            out_occ_next    = prt_pkg::occ_of(count_next);
                            for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
                            begin
                                cell_ctl[i].shift = 1'b1;
                            end
                        end
                        else
                        begin
                            out_status_next = prt_pkg::ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        out_status_next = prt_pkg::ST_TICKNONE;
                    end
                endcase
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (cell_stat[0].expired)
                    begin
                        out_status_next = prt_pkg::ST_EXPIRED;
                        out_entry_next  = cell_entry[0];
                        count_next      = count_reg - prt_pkg::CNT_W'(1);
                        out_occ_next    = prt_pkg::occ_of(count_next);
                        out_last_next   = !cell_stat[1].expired;
                        for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
                        begin
                            cell_ctl[i].shift = 1'b1;
                        end
                        if (!cell_stat[1].expired)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        out_status_next = prt_pkg::ST_TICKNONE;
                        out_entry_next  = '0;
                        out_occ_next    = prt_pkg::occ_of(count_reg);
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            now_reg        <= '0;
            timeout_reg    <= 16'd3;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            timeout_reg    <= timeout_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        addr_reg       <= addr_next;
        port_reg       <= port_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_occ_reg    <= out_occ_next;
        out_last_reg   <= out_last_next;
    end

    for (genvar g = 0; g < prt_pkg::TABLE_DEPTH; g++)
    begin : g_cell
        prt_pkg::entry_t nb_entry;
        logic            nb_valid;

        if (g < prt_pkg::TABLE_DEPTH - 1)
        begin : g_mid
            assign nb_entry = cell_entry[g+1];
            assign nb_valid = cell_stat[g+1].valid;
        end
        else
        begin : g_end
            assign nb_entry = '0;
            assign nb_valid = 1'b0;
        end

        prt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[g]),
            .load_entry (new_entry),
            .next_entry (nb_entry),
            .next_valid (nb_valid),
            .cmp_id     (id_reg),
            .now        (now_reg),
            .entry      (cell_entry[g]),
            .stat       (cell_stat[g])
        );
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.entry_id   = out_entry_reg.id;
    assign rsp.entry_addr = out_entry_reg.addr;
    assign rsp.entry_port = out_entry_reg.port;
    assign rsp.occupancy  = out_occ_reg;
    assign rsp.last       = out_last_reg;

endmodule

@@ rtl/pending_request_timeout_table_checker.sv @@
// Port-level assertions of the pending request timeout table and their bind.
`include "pending_request_timeout_table_macros.svh"

module pending_request_timeout_table_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [4:0]  occupancy,
    input logic        last
);

    logic busy_reg;
    logic busy_next;
    logic in_take;
    logic out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        busy_next = busy_reg;
        if (out_take && last)
        begin
            busy_next = 1'b0;
        end
        if (in_take)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    `PRT_ASSERT_IMP(a_one_request_at_a_time, clk, rst_n, in_take, !busy_reg || (out_take && last))
    `PRT_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(occupancy) && $stable(last))
    `PRT_ASSERT_IMP(a_single_result_is_last, clk, rst_n, out_valid && (status != prt_pkg::ST_EXPIRED), last)
    `PRT_ASSERT_IMP(a_occupancy_bound, clk, rst_n, out_valid, 32'(occupancy) <= 32'(prt_pkg::TABLE_DEPTH))

endmodule

bind pending_request_timeout_table pending_request_timeout_table_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .occupancy (rsp.occupancy),
    .last      (rsp.last)
);

@@ test/pending_request_timeout_table_tb.sv @@
// Self-checking testbench for the pending request timeout table, with its own table predictor.
module pending_request_timeout_table_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] id;
        logic [31:0] addr;
        logic [15:0] port;
        logic [4:0]  occupancy;
        logic        last;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        timeout_we;
    logic [15:0] timeout_wdata;

    prt_req_if req_bus ();
    prt_rsp_if rsp_bus ();

    pending_request_timeout_table i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_bus),
        .rsp           (rsp_bus),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata)
    );

    // Predicted table contents, in insertion order
    logic [15:0]   held_id [prt_pkg::TABLE_DEPTH];
    logic [31:0]   held_addr [prt_pkg::TABLE_DEPTH];
    logic [15:0]   held_port [prt_pkg::TABLE_DEPTH];
    logic [31:0]   held_expiry [prt_pkg::TABLE_DEPTH];
    int            held_count;
    logic [31:0]   seconds_now;
    logic [15:0]   timeout_setting;

    table_result_t pending_results[$];
    table_result_t front_result;
    logic [15:0]   id_pool [24];
    int            error_count;
    int            quiet_cycles;
    int            rsp_hold_cycles;
    bit            no_idle;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int find_held(input logic [15:0] id);
        for (int i = 0; i < held_count; i++)
            if (held_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void drop_held(input int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_id[i]     = held_id[i + 1];
            held_addr[i]   = held_addr[i + 1];
            held_port[i]   = held_port[i + 1];
            held_expiry[i] = held_expiry[i + 1];
        end
        held_count--;
    endfunction

    function automatic void push_result(input logic [2:0] status, input int pos,
                                        input bit with_entry, input bit last);
        table_result_t r;
        r.status = status;
        r.id     = with_entry ? held_id[pos] : 16'h0;
        r.addr   = with_entry ? held_addr[pos] : 32'h0;
        r.port   = with_entry ? held_port[pos] : 16'h0;
        if (with_entry)
            drop_held(pos);
        r.occupancy = held_count[4:0];
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(input logic [1:0] op, input logic [15:0] id,
                                            input logic [31:0] addr, input logic [15:0] port);
        int pos;
        int popped;
        popped = 0;
        case (op) inside
            prt_pkg::OP_INSERT:
            begin
                if (find_held(id) >= 0)
                    push_result(prt_pkg::ST_DUPLICATE, 0, 1'b0, 1'b1);
                else if (held_count >= prt_pkg::TABLE_DEPTH)
                    push_result(prt_pkg::ST_FULL, 0, 1'b0, 1'b1);
                else
                begin
                    held_id[held_count]     = id;
                    held_addr[held_count]   = addr;
                    held_port[held_count]   = port;
                    held_expiry[held_count] = seconds_now + {16'h0, timeout_setting};
                    held_count++;
                    push_result(prt_pkg::ST_INSERTED, 0, 1'b0, 1'b1);
                end
            end
            prt_pkg::OP_REMOVE_ID, prt_pkg::OP_REMOVE_HD:
            begin
                pos = (op == prt_pkg::OP_REMOVE_ID) ? find_held(id) :
                      (held_count > 0 ? 0 : -1);
                if (pos < 0)
                    push_result(prt_pkg::ST_NOTFOUND, 0, 1'b0, 1'b1);
                else
                    push_result(prt_pkg::ST_REMOVED, pos, 1'b1, 1'b1);
            end
            default:
            begin
                seconds_now = seconds_now + 32'd1;
                while (held_count > 0 && held_expiry[0] <= seconds_now)
                begin
                    push_result(prt_pkg::ST_EXPIRED, 0, 1'b1, 1'b0);
                    popped++;
                end
                if (popped == 0)
                    push_result(prt_pkg::ST_TICKNONE, 0, 1'b0, 1'b1);
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [15:0] id,
                                input logic [31:0] addr, input logic [15:0] port);
        int gap;
        req_bus.valid      <= 1'b1;
        req_bus.op         <= op;
        req_bus.request_id <= id;
        req_bus.peer_addr  <= addr;
        req_bus.peer_port  <= port;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
        predict_request(op, id, addr, port);
        gap = idle_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain_results();
        @(posedge clk);
        timeout_we    <= 1'b1;
        timeout_wdata <= value;
        @(posedge clk);
        timeout_we      <= 1'b0;
        timeout_setting = value;
    endtask

    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'($urandom_range(0, 65535));
        return id_pool[$urandom_range(0, 23)];
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 9))
            0:       return 16'h0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random();
        int          r;
        logic [1:0]  op;
        logic [15:0] id;
        r  = $urandom_range(0, 99);
        id = pick_id();
        if (r < 40)
            op = prt_pkg::OP_INSERT;
        else if (r < 58)
        begin
            op = prt_pkg::OP_REMOVE_ID;
            if (held_count > 0 && $urandom_range(0, 3) != 0)
                id = held_id[$urandom_range(0, held_count - 1)];
        end
        else if (r < 68)
            op = prt_pkg::OP_REMOVE_HD;
        else
            op = prt_pkg::OP_TICK;
        send_request(op, id, pick_addr(), pick_port());
    endtask

    task automatic test_empty_table();
        send_request(prt_pkg::OP_REMOVE_HD, 16'h0, 32'h0, 16'h0);
        send_request(prt_pkg::OP_REMOVE_ID, 16'h1234, 32'h0, 16'h0);
        send_request(prt_pkg::OP_TICK, 16'h0, 32'h0, 16'h0);
        send_request(prt_pkg::OP_INSERT, 16'h0, 32'h0, 16'h0);
        send_request(prt_pkg::OP_INSERT, 16'h0, 32'hDEAD_BEEF, 16'h5A5A);
        send_request(prt_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(prt_pkg::OP_REMOVE_ID, 16'hFFFF, 32'h0, 16'h0);
        send_request(prt_pkg::OP_REMOVE_ID, 16'h5555, 32'h0, 16'h0);
        send_request(prt_pkg::OP_REMOVE_HD, 16'h0, 32'h0, 16'h0);
    endtask

    task automatic test_fill_and_expire();
        write_timeout(16'h0);
        for (int i = 0; i < prt_pkg::TABLE_DEPTH; i++)
            send_request(prt_pkg::OP_INSERT, 16'h0A50 + 16'(i * 16'h1111), $urandom, 16'(i));
        send_request(prt_pkg::OP_INSERT, 16'hBEEF, 32'h1, 16'h1);
        send_request(prt_pkg::OP_INSERT, held_id[3], 32'h2, 16'h2);
        send_request(prt_pkg::OP_REMOVE_ID, held_id[7], 32'h0, 16'h0);
        send_request(prt_pkg::OP_INSERT, 16'hBEEF, 32'h3, 16'h3);
        send_request(prt_pkg::OP_TICK, 16'h0, 32'h0, 16'h0);
    endtask

    task automatic test_random_timeouts();
        logic [15:0] settings [5];
        settings[0] = 16'd3;
        settings[1] = 16'd1;
        settings[2] = 16'hFFFF;
        settings[3] = 16'($urandom_range(2, 9));
        settings[4] = 16'd0;
        for (int s = 0; s < 5; s++)
        begin
            write_timeout(settings[s]);
            repeat (60) send_random();
        end
    endtask

    task automatic test_result_stall();
        write_timeout(16'd2);
        // hold the result side while requests keep coming
        rsp_hold_cycles = HOLD_CYCLES;
        repeat (30) send_random();
    endtask

    task automatic test_sender_pause();
        drain_results();
        repeat (20) send_random();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (40) send_random();
        no_idle = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        int n;
        stall = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles > 0)
            begin
                n               = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_bus.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual status %0d", $time,
                         rsp_bus.status);
                error_count++;
            end
            else
            begin
                front_result = pending_results.pop_front();
                check_field("status", 32'(front_result.status), 32'(rsp_bus.status));
                check_field("entry_id", 32'(front_result.id), 32'(rsp_bus.entry_id));
                check_field("entry_addr", front_result.addr, rsp_bus.entry_addr);
                check_field("entry_port", 32'(front_result.port), 32'(rsp_bus.entry_port));
                check_field("occupancy", 32'(front_result.occupancy), 32'(rsp_bus.occupancy));
                check_field("last", 32'(front_result.last), 32'(rsp_bus.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, pending_results.size());
            $display("pending_request_timeout_table verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        timeout_we         = 1'b0;
        timeout_wdata      = 16'h0;
        req_bus.valid      = 1'b0;
        req_bus.op         = prt_pkg::OP_INSERT;
        req_bus.request_id = 16'h0;
        req_bus.peer_addr  = 32'h0;
        req_bus.peer_port  = 16'h0;
        held_count         = 0;
        seconds_now        = 32'h0;
        timeout_setting    = 16'd3;
        error_count        = 0;
        quiet_cycles       = 0;
        rsp_hold_cycles    = 0;
        no_idle            = 1'b0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++)
            id_pool[i] = 16'($urandom_range(0, 65535));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_expire();
        test_random_timeouts();
        test_result_stall();
        test_sender_pause();
        test_back_to_back();

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("pending_request_timeout_table verification clean");
        else
            $display("pending_request_timeout_table verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/prt_pkg.sv
rtl/prt_if.sv
rtl/prt_cell.sv
rtl/pending_request_timeout_table.sv
rtl/pending_request_timeout_table_checker.sv
test/pending_request_timeout_table_tb.sv
